// ===== sv/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
// Depends on nothing; used by the controller, the datapath, the top level and the checker.
package wpm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int CHAR_BITS_DEF   = 8;

    // Wildcard codes ('*' and '?')
    localparam int STAR_CODE = 42;
    localparam int ANY_CODE  = 63;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;     // take the request: latch it, update length, seed column 0
        logic reject;    // full-store append: keep the row, flag the result
        logic issue;     // read the next column and advance the column counter
        logic load_out;  // copy status into the output register
    } cmd_t;

    typedef struct packed {
        logic full;        // pattern store holds MAX_PATTERN characters
        logic len_zero;    // pattern is empty
        logic issue_last;  // column being issued is the last one
    } status_t;

endpackage

// ===== sv/wpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wpm_ctrl.sv =====
// Controller state machine for the wildcard pattern matcher.
// Depends on wpm_pkg (state, command and status types).
module wpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  wpm_pkg::status_t  status,
    output wpm_pkg::cmd_t     cmd
);

    wpm_pkg::state_t state_reg;
    wpm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    wpm_pkg::kind_t  in_kind;
    logic            rejecting;
    logic            go_sweep;
    logic            out_free;

    assign in_kind   = wpm_pkg::kind_t'(kind);
    assign rejecting = (in_kind == wpm_pkg::KIND_APPEND) && status.full;
    assign go_sweep  = (in_kind == wpm_pkg::KIND_APPEND) ||
                       (((in_kind == wpm_pkg::KIND_TEXT) ||
                         (in_kind == wpm_pkg::KIND_RESTART)) && !status.len_zero);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!rejecting && go_sweep)
                    begin
                        state_next = wpm_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = wpm_pkg::ST_DONE;
                    end
                end
            end
            wpm_pkg::ST_SWEEP:
            begin
                if (status.issue_last)
                begin
                    state_next = wpm_pkg::ST_DRAIN;
                end
            end
            wpm_pkg::ST_DRAIN:
            begin
                state_next = wpm_pkg::ST_DONE;
            end
            wpm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = wpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            wpm_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.start  = in_valid && !rejecting;
                cmd.reject = in_valid && rejecting;
            end
            wpm_pkg::ST_SWEEP:
            begin
                cmd.issue = 1'b1;
            end
            wpm_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            wpm_pkg::ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/wpm_dpath.sv =====
// Datapath: pattern store, match row store, column sweep logic and result register.
// Depends on wpm_pkg (command/status types, codes) and wpm_ram.
module wpm_dpath #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = wpm_pkg::CHAR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wpm_pkg::cmd_t        cmd,
    input  logic [1:0]           kind,
    input  logic [CHAR_BITS-1:0] character,
    output wpm_pkg::status_t     status,
    output logic                 matched,
    output logic                 can_still_match,
    output logic                 rejected
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [CHAR_BITS-1:0] STAR_C = CHAR_BITS'(wpm_pkg::STAR_CODE);
    localparam logic [CHAR_BITS-1:0] ANY_C  = CHAR_BITS'(wpm_pkg::ANY_CODE);

    wpm_pkg::kind_t       in_kind;
    wpm_pkg::kind_t       kind_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [ADDR_W-1:0]    issue_addr_reg;
    logic [ADDR_W-1:0]    proc_addr_reg;
    logic                 pipe_valid_reg;
    logic                 pipe_last_reg;
    logic                 row0_reg;
    logic                 prev_old_reg;
    logic                 prev_new_reg;
    logic                 any_reg;
    logic                 matched_reg;
    logic                 rejected_reg;
    logic                 out_matched_reg;
    logic                 out_any_reg;
    logic                 out_rejected_reg;
    logic                 new0;
    logic                 new_j;
    logic                 pat_we;
    logic [CHAR_BITS-1:0] pat_rdata;
    logic                 row_rdata;

    assign in_kind = wpm_pkg::kind_t'(kind);
    assign new0    = (in_kind != wpm_pkg::KIND_TEXT);
    assign pat_we  = cmd.start && (in_kind == wpm_pkg::KIND_APPEND);

    wpm_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_pattern (
        .clk   (clk),
        .we    (pat_we),
        .waddr (ADDR_W'(len_reg)),
        .wdata (character),
        .raddr (issue_addr_reg),
        .rdata (pat_rdata)
    );

    // Entry a holds row position a + 1; position 0 lives in row0_reg.
    wpm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PATTERN)
    ) u_row (
        .clk   (clk),
        .we    (pipe_valid_reg),
        .waddr (proc_addr_reg),
        .wdata (new_j),
        .raddr (issue_addr_reg),
        .rdata (row_rdata)
    );

    // One column of the row update; equality wins over the wildcards.
    always_comb
    begin
        if (kind_reg != wpm_pkg::KIND_TEXT)
        begin
            new_j = prev_new_reg && (pat_rdata == STAR_C);
        end
        else if ((pat_rdata == char_reg) || (pat_rdata == ANY_C))
        begin
            new_j = prev_old_reg;
        end
        else if (pat_rdata == STAR_C)
        begin
            new_j = prev_new_reg || row_rdata;
        end
        else
        begin
            new_j = 1'b0;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.start)
        begin
            case (in_kind)
                wpm_pkg::KIND_APPEND:  len_next = len_reg + LEN_W'(1);
                wpm_pkg::KIND_CLEAR:   len_next = '0;
                default:               len_next = len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            issue_addr_reg   <= '0;
            pipe_valid_reg   <= 1'b0;
            pipe_last_reg    <= 1'b0;
            row0_reg         <= 1'b1;
            any_reg          <= 1'b1;
            matched_reg      <= 1'b1;
            rejected_reg     <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            pipe_valid_reg <= cmd.issue;
            if (cmd.start)
            begin
                issue_addr_reg <= '0;
                row0_reg       <= new0;
                any_reg        <= new0;
                matched_reg    <= new0;
                rejected_reg   <= 1'b0;
            end
            else if (cmd.reject)
            begin
                rejected_reg <= 1'b1;
            end
            if (cmd.issue)
            begin
                issue_addr_reg <= issue_addr_reg + ADDR_W'(1);
                pipe_last_reg  <= status.issue_last;
            end
            if (pipe_valid_reg)
            begin
                any_reg <= any_reg || new_j;
                if (pipe_last_reg)
                begin
                    matched_reg <= new_j;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg     <= in_kind;
            char_reg     <= character;
            prev_new_reg <= new0;
            prev_old_reg <= row0_reg;
        end
        if (cmd.issue)
        begin
            proc_addr_reg <= issue_addr_reg;
        end
        if (pipe_valid_reg)
        begin
            prev_new_reg <= new_j;
            prev_old_reg <= row_rdata;
        end
        if (cmd.load_out)
        begin
            out_matched_reg  <= matched_reg;
            out_any_reg      <= any_reg;
            out_rejected_reg <= rejected_reg;
        end
    end

    assign status.full       = (len_reg == LEN_W'(MAX_PATTERN));
    assign status.len_zero   = (len_reg == '0);
    assign status.issue_last = ((LEN_W'(issue_addr_reg) + LEN_W'(1)) == len_reg);

    assign matched         = out_matched_reg;
    assign can_still_match = out_any_reg;
    assign rejected        = out_rejected_reg;

endmodule

// ===== sv/wildcard_pattern_match.sv =====
// Top level of the wildcard pattern matcher: controller plus datapath.
// Depends on wpm_pkg, wpm_ctrl, wpm_dpath (and through it wpm_ram).
//
// Glob matcher for '?' (any one character) and '*' (any run, empty included).
// Each request carries a kind and a character: append a pattern character,
// clear the pattern, feed a text character, or restart the text. Every request
// returns one result: matched (text since the last row reset matches the whole
// pattern), can_still_match (some prefix of the pattern is still alive) and
// rejected (an append was refused because the store already holds MAX_PATTERN
// characters; the row is then left as it was). A pattern character equal to
// the text character matches literally before the wildcards are considered.
// Timing: the match row is updated one pattern column per cycle, reading the
// pattern store and the row store (both single-port-read RAMs) in a pipelined
// sweep. A clear, a rejected append, or a text or restart request on an empty
// pattern skips the sweep and goes straight from acceptance to loading the
// result. Every other request is accepted, sweeps the L columns of the
// pattern (L being the pattern length after the request), drains the read
// pipeline and then loads the output register once the output is free. One
// request is in work at a time; a new one is accepted while the previous
// result still waits on the output. No clearing pass is needed after reset.
module wildcard_pattern_match #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = wpm_pkg::CHAR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [CHAR_BITS-1:0] character,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 matched,
    output logic                 can_still_match,
    output logic                 rejected
);

    wpm_pkg::cmd_t    cmd;
    wpm_pkg::status_t status;

    // Sequence requests: accept, sweep the columns, drain, present the result.
    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the pattern and match row; compute one column per cycle.
    wpm_dpath #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_BITS   (CHAR_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .character       (character),
        .status          (status),
        .matched         (matched),
        .can_still_match (can_still_match),
        .rejected        (rejected)
    );

endmodule

// ===== sv/wpm_checker.sv =====
// Port-level assertions for wildcard_pattern_match, attached by bind.
// Depends on wpm_pkg (request kinds).
module wpm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic       matched,
    input logic       can_still_match,
    input logic       rejected
);

    logic           push;
    logic           pop;
    logic [1:0]     count_reg;
    logic [1:0]     count_after_pop;
    wpm_pkg::kind_t slot0_reg;
    wpm_pkg::kind_t slot1_reg;

    assign push            = in_valid && in_ready;
    assign pop             = out_valid && out_ready;
    assign count_after_pop = count_reg - {1'b0, pop};

    // Track the kinds of requests whose results are not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot0_reg <= wpm_pkg::KIND_APPEND;
            slot1_reg <= wpm_pkg::KIND_APPEND;
        end
        else
        begin
            count_reg <= count_after_pop + {1'b0, push};
            if (push && (count_after_pop == 2'd0))
            begin
                slot0_reg <= wpm_pkg::kind_t'(kind);
            end
            else
            begin
                if (pop)
                begin
                    slot0_reg <= slot1_reg;
                end
                if (push)
                begin
                    slot1_reg <= wpm_pkg::kind_t'(kind);
                end
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched)
            && $stable(can_still_match) && $stable(rejected))
        else $error("result changed or dropped while stalled");

    a_match_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> can_still_match)
        else $error("matched without any live row bit");

    a_reject_append: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> slot0_reg == wpm_pkg::KIND_APPEND)
        else $error("rejected flag on a request that was not an append");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slot0_reg == wpm_pkg::KIND_CLEAR)
            |-> matched && can_still_match && !rejected)
        else $error("clear must leave an empty pattern that matches");

    a_restart_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slot0_reg == wpm_pkg::KIND_RESTART)
            |-> can_still_match && !rejected)
        else $error("restart must leave position zero set");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (.*);
